// File: rtl/bffa_pkg.sv
package bffa_pkg;

   // Table geometry and field widths.
   localparam int FREE_ENTRIES = 32;
   localparam int ADDR_BITS    = 32;
   localparam int PTR_W        = $clog2(FREE_ENTRIES);
   localparam int IDX_W        = $clog2(FREE_ENTRIES + 1);
   localparam int DATA_W       = 32;
   localparam int SHIFT_W      = 5;
   localparam int HDR_W        = 7;
   localparam int STATUS_W     = 3;
   localparam int REGION_W     = DATA_W + 2;
   localparam int END_W        = ((ADDR_BITS > REGION_W) ? ADDR_BITS : REGION_W) + 1;

   // Register values after reset.
   localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST   = SHIFT_W'(12);
   localparam logic [HDR_W-1:0]   HEADER_BYTES_RST = HDR_W'(16);
   localparam logic [DATA_W-1:0]  REGION_BASE_RST  = 32'h1000_0000;
   localparam logic [DATA_W-1:0]  REGION_LIMIT_RST = 32'h2000_0000;

   typedef enum logic [1:0] {
      CSR_PAGE_SHIFT   = 2'd0,
      CSR_HEADER_BYTES = 2'd1,
      CSR_REGION_BASE  = 2'd2,
      CSR_REGION_LIMIT = 2'd3
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_REUSED     = 3'd0,
      ST_NEW_REGION = 3'd1,
      ST_FREED      = 3'd2,
      ST_NULL       = 3'd3,
      ST_DOUBLE     = 3'd4,
      ST_FULL       = 3'd5,
      ST_NO_MEMORY  = 3'd6
   } status_type;

   typedef struct packed {
      logic [SHIFT_W-1:0] page_shift;
      logic [HDR_W-1:0]   header_bytes;
      logic [DATA_W-1:0]  region_limit;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic scan_rd;
      logic scan_cmp;
      logic region_a;
      logic region_b;
      logic post_fix;
      logic post_push;
      logic post_reuse;
      logic post_region;
      logic shift_rd;
      logic shift_wr;
      logic pop;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_free;
      logic addr_null;
      logic scan_more;
      logic shift_more;
      logic found;
      logic dup;
      logic full;
      logic rsp_busy;
   } dp_sts_type;

endpackage

// File: rtl/best_fit_free_block_allocator_core.sv
// Best-fit free-list allocator; one word in gives one word out. A new request word
// is taken only after the last one has posted its result and finished any table update;
// a result that waits on the result channel holds back the posting of the next result,
// not the taking of the next word.
// Reset (synchronous, active high) empties the table, loads the bump pointer
// with the region base reset value and restores the control and configuration registers.
module best_fit_free_block_allocator_core (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata, from bit 0: req_size[31:0], block_addr[63:32], block_size[95:64].
   input  logic [3*bffa_pkg::DATA_W-1:0]       req_tdata,
   // tuser: req_type (0 allocate, 1 free).
   input  logic                                req_tuser,
   // Result channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata, from bit 0: out_addr[31:0], out_size[63:32].
   output logic [2*bffa_pkg::DATA_W-1:0]       rsp_tdata,
   // tuser: status[2:0].
   output logic [bffa_pkg::STATUS_W-1:0]       rsp_tuser,
   // Register write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [bffa_pkg::DATA_W-1:0]         csr_data
);
   import bffa_pkg::*;

   cfg_type    cfg;
   dp_cmd_type cmd;
   dp_sts_type sts;

   // The register block holds page size, header length and region limit.
   bffa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The controller sequences each request: unless a free names a null address, it
   // scans the listed blocks for the best fit or a duplicate address, then posts the
   // result and, when the table changes, updates it, either pushing at the head or
   // closing the gap one entry at a time after a block is taken.
   bffa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the free table as a ring in a one-port-each memory,
   // the bump pointer, the region arithmetic and the result register.
   bffa_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: rtl/bffa_csr.sv
module bffa_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [bffa_pkg::DATA_W-1:0]         csr_data,
   output bffa_pkg::cfg_type                   cfg
);
   import bffa_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // The region base only seeds the bump pointer at reset, so a written base
   // is accepted and has no further effect.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.page_shift   <= PAGE_SHIFT_RST;
         cfg_ff.header_bytes <= HEADER_BYTES_RST;
         cfg_ff.region_limit <= REGION_LIMIT_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_PAGE_SHIFT:   cfg_ff.page_shift   <= csr_data[SHIFT_W-1:0];
            CSR_HEADER_BYTES: cfg_ff.header_bytes <= csr_data[HDR_W-1:0];
            CSR_REGION_LIMIT: cfg_ff.region_limit <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

// File: rtl/bffa_ctrl.sv
module bffa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  bffa_pkg::dp_sts_type   sts,
   output bffa_pkg::dp_cmd_type   cmd
);
   import bffa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_DECIDE,
      S_FIX,
      S_PUSH,
      S_REUSE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_REGION_A,
      S_REGION_B,
      S_BUMP
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   assign req_tready = ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.is_free && sts.addr_null) begin
               state_in = S_FIX;
            end else if (sts.scan_more) begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_SCAN: begin
            cmd.scan_cmp = 1'b1;
            if (sts.scan_more) begin
               cmd.scan_rd = 1'b1;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (sts.is_free) begin
               state_in = (sts.dup || sts.full) ? S_FIX : S_PUSH;
            end else begin
               state_in = sts.found ? S_REUSE : S_REGION_A;
            end
         end
         S_FIX: begin
            if (!sts.rsp_busy) begin
               cmd.post_fix = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_PUSH: begin
            if (!sts.rsp_busy) begin
               cmd.post_push = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_REUSE: begin
            if (!sts.rsp_busy) begin
               cmd.post_reuse = 1'b1;
               state_in       = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            if (sts.shift_more) begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHIFT_WR;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_REGION_A: begin
            cmd.region_a = 1'b1;
            state_in     = S_REGION_B;
         end
         S_REGION_B: begin
            cmd.region_b = 1'b1;
            state_in     = S_BUMP;
         end
         S_BUMP: begin
            if (!sts.rsp_busy) begin
               cmd.post_region = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

endmodule

// File: rtl/bffa_dp.sv
module bffa_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  bffa_pkg::cfg_type                   cfg,
   input  bffa_pkg::dp_cmd_type                cmd,
   output bffa_pkg::dp_sts_type                sts,
   input  logic [3*bffa_pkg::DATA_W-1:0]       req_tdata,
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [2*bffa_pkg::DATA_W-1:0]       rsp_tdata,
   output logic [bffa_pkg::STATUS_W-1:0]       rsp_tuser
);
   import bffa_pkg::*;

   // Map a list position onto a table slot; the list is a ring that starts at
   // the head slot and runs upward; a push adds its entry below the head slot.
   function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [IDX_W-1:0] pos);
      logic [IDX_W:0] sum;
      sum = (IDX_W+1)'(head) + (IDX_W+1)'(pos);
      if (sum >= (IDX_W+1)'(FREE_ENTRIES)) begin
         sum = sum - (IDX_W+1)'(FREE_ENTRIES);
      end
      return PTR_W'(sum);
   endfunction

   // Free table: user address in the low half, usable size in the high half.
   logic [2*DATA_W-1:0] mem [FREE_ENTRIES];
   logic [2*DATA_W-1:0] rd_data_ff;
   logic                rd_en, wr_en;
   logic [PTR_W-1:0]    rd_addr, wr_addr;
   logic [2*DATA_W-1:0] wr_data;

   logic                is_free_ff;
   logic [DATA_W-1:0]   req_size_ff, block_addr_ff, block_size_ff;

   logic [IDX_W-1:0]    idx_ff, rd_idx_ff, count_ff, best_idx_ff;
   logic [PTR_W-1:0]    head_ff, head_dec;
   logic                found_ff, dup_ff;
   logic [DATA_W-1:0]   best_addr_ff, best_size_ff;

   logic [ADDR_BITS-1:0] bump_ff;
   logic                 tot_zero_ff;
   logic [REGION_W-1:0]  tm1_ff, region_ff;
   logic [REGION_W-1:0]  total_w, page_mask;
   logic [END_W-1:0]     end_w;
   logic [ADDR_BITS-1:0] grant_addr;
   logic                 no_memory;

   logic                 rsp_valid_ff;
   logic [DATA_W-1:0]    rsp_addr_ff, rsp_size_ff;
   status_type           rsp_status_ff;

   logic [DATA_W-1:0]    ent_addr, ent_size;
   logic                 fits;

   assign ent_addr = rd_data_ff[DATA_W-1:0];
   assign ent_size = rd_data_ff[2*DATA_W-1:DATA_W];
   assign fits     = (ent_size >= req_size_ff) && (!found_ff || (ent_size < best_size_ff));

   assign head_dec = (head_ff == '0) ? PTR_W'(FREE_ENTRIES - 1) : head_ff - 1'b1;

   assign rd_en   = cmd.scan_rd || cmd.shift_rd;
   assign rd_addr = cmd.shift_rd ? slot_of(head_ff, idx_ff + 1'b1) : slot_of(head_ff, idx_ff);
   assign wr_en   = cmd.post_push || cmd.shift_wr;
   assign wr_addr = cmd.post_push ? head_dec : slot_of(head_ff, idx_ff);
   assign wr_data = cmd.post_push ? {block_size_ff, block_addr_ff} : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Fresh region arithmetic, spread over three steps.
   assign total_w   = REGION_W'(req_size_ff) + REGION_W'(cfg.header_bytes);
   assign page_mask = (REGION_W'(1) << cfg.page_shift) - 1'b1;
   assign end_w     = END_W'(bump_ff) + END_W'(region_ff);
   assign no_memory = end_w > END_W'(cfg.region_limit);
   assign grant_addr = bump_ff + ADDR_BITS'(cfg.header_bytes);

   assign sts.is_free    = is_free_ff;
   assign sts.addr_null  = (block_addr_ff == '0);
   assign sts.scan_more  = (idx_ff < count_ff);
   assign sts.shift_more = ((idx_ff + 1'b1) < count_ff);
   assign sts.found      = found_ff;
   assign sts.dup        = dup_ff;
   assign sts.full       = (count_ff == IDX_W'(FREE_ENTRIES));
   assign sts.rsp_busy   = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_size_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         is_free_ff    <= req_tuser;
         req_size_ff   <= req_tdata[DATA_W-1:0];
         block_addr_ff <= req_tdata[2*DATA_W-1:DATA_W];
         block_size_ff <= req_tdata[3*DATA_W-1:2*DATA_W];
      end
      if (cmd.scan_cmp && fits) begin
         best_idx_ff  <= rd_idx_ff;
         best_addr_ff <= ent_addr;
         best_size_ff <= ent_size;
      end
      if (cmd.region_a) begin
         tot_zero_ff <= (total_w == '0);
         tm1_ff      <= total_w - 1'b1;
      end
      if (cmd.region_b) begin
         region_ff <= tot_zero_ff ? (REGION_W'(1) << cfg.page_shift)
                                  : ((tm1_ff | page_mask) + 1'b1);
      end
      if (cmd.post_fix) begin
         rsp_addr_ff   <= '0;
         rsp_size_ff   <= '0;
         rsp_status_ff <= block_addr_ff == '0 ? ST_NULL : (dup_ff ? ST_DOUBLE : ST_FULL);
      end
      if (cmd.post_push) begin
         rsp_addr_ff   <= '0;
         rsp_size_ff   <= '0;
         rsp_status_ff <= ST_FREED;
      end
      if (cmd.post_reuse) begin
         rsp_addr_ff   <= best_addr_ff;
         rsp_size_ff   <= best_size_ff;
         rsp_status_ff <= ST_REUSED;
      end
      if (cmd.post_region) begin
         if (no_memory) begin
            rsp_addr_ff   <= '0;
            rsp_size_ff   <= '0;
            rsp_status_ff <= ST_NO_MEMORY;
         end else begin
            rsp_addr_ff   <= DATA_W'(grant_addr);
            rsp_size_ff   <= DATA_W'(region_ff - REGION_W'(cfg.header_bytes));
            rsp_status_ff <= ST_NEW_REGION;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rd_idx_ff    <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
         found_ff     <= 1'b0;
         dup_ff       <= 1'b0;
         bump_ff      <= ADDR_BITS'(REGION_BASE_RST);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
            dup_ff   <= 1'b0;
         end
         if (cmd.scan_rd) begin
            rd_idx_ff <= idx_ff;
            idx_ff    <= idx_ff + 1'b1;
         end
         if (cmd.scan_cmp) begin
            if (fits) begin
               found_ff <= 1'b1;
            end
            if (ent_addr == block_addr_ff) begin
               dup_ff <= 1'b1;
            end
         end
         if (cmd.post_reuse) begin
            idx_ff <= best_idx_ff;
         end
         if (cmd.shift_wr) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.pop) begin
            count_ff <= count_ff - 1'b1;
         end
         if (cmd.post_push) begin
            head_ff  <= head_dec;
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.post_region && !no_memory) begin
            bump_ff <= ADDR_BITS'(end_w);
         end
         if (cmd.post_fix || cmd.post_push || cmd.post_reuse || cmd.post_region) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
